/* rtl/wavhp_pkg.sv */
`default_nettype none

package wavhp_pkg;

  localparam int LIST_LIMIT_DEF = 500;

  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_LIST = 32'h4C49_5354;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;
  localparam logic [31:0] FMT_LEN  = 32'h0000_0010;
  localparam logic [15:0] FMT_PCM  = 16'h0001;

  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_RIFF_TAG  = 4'd1;
  localparam logic [3:0] ST_RIFF_SIZE = 4'd2;
  localparam logic [3:0] ST_WAVE_TAG  = 4'd3;
  localparam logic [3:0] ST_FMT_TAG   = 4'd4;
  localparam logic [3:0] ST_FMT_SIZE  = 4'd5;
  localparam logic [3:0] ST_FORMAT    = 4'd6;
  localparam logic [3:0] ST_CHANNELS  = 4'd7;
  localparam logic [3:0] ST_BITS      = 4'd8;
  localparam logic [3:0] ST_LIST_SIZE = 4'd9;
  localparam logic [3:0] ST_DATA_TAG  = 4'd10;

  localparam int RESULT_W = 143;
  localparam int TDATA_W  = 144;

  typedef struct packed {
    logic [7:0] header_byte;
    logic       first_byte;
  } wavhp_item_t;

  // first member is the top bits: fields listed high to low
  typedef struct packed {
    logic [8:0]  header_length;
    logic [31:0] data_size;
    logic [15:0] sample_bits;
    logic [15:0] block_align;
    logic [31:0] byte_rate;
    logic [31:0] sample_rate;
    logic [1:0]  channel_count;
    logic [3:0]  status;
  } wavhp_result_t;

  function automatic logic [31:0] le_word(input logic [31:0] w);
    return {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

  function automatic logic [15:0] le_half(input logic [31:0] w);
    return {w[7:0], w[15:8]};
  endfunction

endpackage

`default_nettype wire

/* rtl/wavhp_in_stage.sv */
`default_nettype none

module wavhp_in_stage (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  s_valid,
  output logic                 s_ready,
  input  wavhp_pkg::wavhp_item_t s_item,
  output logic                 q_valid,
  input  wire                  q_ready,
  output wavhp_pkg::wavhp_item_t q_item
);
  import wavhp_pkg::*;

  assign s_ready = !q_valid || q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (s_ready) begin
      q_valid <= s_valid;
    end
    if (s_ready && s_valid) begin
      q_item <= s_item;
    end
  end

endmodule

`default_nettype wire

/* rtl/wavhp_core.sv */
`default_nettype none

module wavhp_core #(
  parameter int LIST_LIMIT = wavhp_pkg::LIST_LIMIT_DEF
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  wavhp_pkg::wavhp_item_t   in_item,
  input  wire  [31:0]            file_length,
  output logic                   out_valid,
  input  wire                    out_ready,
  output wavhp_pkg::wavhp_result_t out_result
);
  import wavhp_pkg::*;

  localparam int POS_W = $clog2(LIST_LIMIT + 8);
  localparam logic [31:0] LIST_SPAN = 32'(LIST_LIMIT - 44);
  localparam logic [POS_W-1:0] DATA_POS_DEF = POS_W'(36);

  logic [POS_W-1:0] pos, pos_next, pos_e;
  logic [23:0]      word_shift, word_shift_next, ws_e;
  logic             list_seen, list_seen_next, list_e;
  logic [POS_W-1:0] data_pos, data_pos_next, dp_e;
  logic             finished, finished_next, fin_e;
  logic [1:0]       cap_ch, cap_ch_next;
  logic [31:0]      cap_rate, cap_rate_next;
  logic [31:0]      cap_brate, cap_brate_next;
  logic [15:0]      cap_align, cap_align_next;
  logic [15:0]      cap_bits, cap_bits_next;

  logic        fire, emit, handled;
  logic [3:0]  st;
  logic [31:0] dsize;
  logic [8:0]  hlen;
  logic [31:0] w, lew;
  logic [15:0] h;

  assign in_ready = !out_valid || out_ready;
  assign fire     = in_valid && in_ready;

  always_comb begin
    pos_e  = in_item.first_byte ? '0 : pos;
    ws_e   = in_item.first_byte ? '0 : word_shift;
    list_e = in_item.first_byte ? 1'b0 : list_seen;
    dp_e   = in_item.first_byte ? DATA_POS_DEF : data_pos;
    fin_e  = in_item.first_byte ? 1'b0 : finished;

    w   = {ws_e, in_item.header_byte};
    lew = le_word(w);
    h   = le_half(w);

    pos_next        = pos_e;
    word_shift_next = ws_e;
    list_seen_next  = list_e;
    data_pos_next   = dp_e;
    finished_next   = fin_e;
    cap_ch_next     = in_item.first_byte ? '0 : cap_ch;
    cap_rate_next   = in_item.first_byte ? '0 : cap_rate;
    cap_brate_next  = in_item.first_byte ? '0 : cap_brate;
    cap_align_next  = in_item.first_byte ? '0 : cap_align;
    cap_bits_next   = in_item.first_byte ? '0 : cap_bits;

    emit    = 1'b0;
    handled = 1'b0;
    st      = ST_OK;
    dsize   = '0;
    hlen    = '0;

    if (!fin_e) begin
      word_shift_next = w[23:0];
      pos_next        = pos_e + POS_W'(1);
      case (pos_e)
        POS_W'(3): begin
          handled = 1'b1;
          if (w != TAG_RIFF) begin
            emit = 1'b1;
            st   = ST_RIFF_TAG;
          end
        end
        POS_W'(7): begin
          handled = 1'b1;
          if (lew + 32'd8 != file_length) begin
            emit = 1'b1;
            st   = ST_RIFF_SIZE;
          end
        end
        POS_W'(11): begin
          handled = 1'b1;
          if (w != TAG_WAVE) begin
            emit = 1'b1;
            st   = ST_WAVE_TAG;
          end
        end
        POS_W'(15): begin
          handled = 1'b1;
          if (w != TAG_FMT) begin
            emit = 1'b1;
            st   = ST_FMT_TAG;
          end
        end
        POS_W'(19): begin
          handled = 1'b1;
          if (lew != FMT_LEN) begin
            emit = 1'b1;
            st   = ST_FMT_SIZE;
          end
        end
        POS_W'(21): begin
          handled = 1'b1;
          if (h != FMT_PCM) begin
            emit = 1'b1;
            st   = ST_FORMAT;
          end
        end
        POS_W'(23): begin
          handled = 1'b1;
          if (h == 16'd1 || h == 16'd2) begin
            cap_ch_next = h[1:0];
          end else begin
            emit = 1'b1;
            st   = ST_CHANNELS;
          end
        end
        POS_W'(27): begin
          handled       = 1'b1;
          cap_rate_next = lew;
        end
        POS_W'(31): begin
          handled        = 1'b1;
          cap_brate_next = lew;
        end
        POS_W'(33): begin
          handled        = 1'b1;
          cap_align_next = h;
        end
        POS_W'(35): begin
          handled       = 1'b1;
          cap_bits_next = h;
          if (h != 16'd8 && h != 16'd16 && h != 16'd24) begin
            emit = 1'b1;
            st   = ST_BITS;
          end
        end
        POS_W'(39): begin
          if (!list_e && w == TAG_LIST) begin
            handled        = 1'b1;
            list_seen_next = 1'b1;
          end
        end
        default: ;
      endcase

      if (!handled) begin
        if (list_e && pos_e == POS_W'(43)) begin
          if (lew >= LIST_SPAN) begin
            emit = 1'b1;
            st   = ST_LIST_SIZE;
          end else begin
            data_pos_next = lew[POS_W-1:0] + POS_W'(44);
          end
        end else if (pos_e == dp_e + POS_W'(3)) begin
          if (w != TAG_DATA) begin
            emit = 1'b1;
            st   = ST_DATA_TAG;
          end
        end else if (pos_e == dp_e + POS_W'(7)) begin
          emit  = 1'b1;
          st    = ST_OK;
          dsize = lew;
          hlen  = 9'(32'(dp_e) + 32'd8);
        end
      end

      if (emit) begin
        finished_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      word_shift <= '0;
      list_seen  <= 1'b0;
      data_pos   <= DATA_POS_DEF;
      finished   <= 1'b1;
      cap_ch     <= '0;
      cap_rate   <= '0;
      cap_brate  <= '0;
      cap_align  <= '0;
      cap_bits   <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (fire) begin
        pos        <= pos_next;
        word_shift <= word_shift_next;
        list_seen  <= list_seen_next;
        data_pos   <= data_pos_next;
        finished   <= finished_next;
        cap_ch     <= cap_ch_next;
        cap_rate   <= cap_rate_next;
        cap_brate  <= cap_brate_next;
        cap_align  <= cap_align_next;
        cap_bits   <= cap_bits_next;
      end
      if (in_ready) begin
        out_valid <= fire && emit;
      end
    end
    if (fire && emit) begin
      out_result.status        <= st;
      out_result.channel_count <= cap_ch_next;
      out_result.sample_rate   <= cap_rate_next;
      out_result.byte_rate     <= cap_brate_next;
      out_result.block_align   <= cap_align_next;
      out_result.sample_bits   <= cap_bits_next;
      out_result.data_size     <= dsize;
      out_result.header_length <= hlen;
    end
  end

  a_emit_finishes: assert property (@(posedge clk) disable iff (rst)
    fire && emit |=> finished)
    else $error("parser not finished after a result");

  a_first_restarts: assert property (@(posedge clk) disable iff (rst)
    fire && in_item.first_byte |=> !finished && pos == POS_W'(1))
    else $error("first byte did not restart the parse");

  a_err_no_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_result.status != ST_OK |->
      out_result.data_size == '0 && out_result.header_length == '0)
    else $error("error result carries data fields");

  a_ok_channels: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_result.status == ST_OK |-> out_result.channel_count != 2'd0)
    else $error("ok result without channel count");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    32'(pos) <= 32'(LIST_LIMIT + 7))
    else $error("byte position out of range");

endmodule

`default_nettype wire

/* rtl/wav_header_parser_unit.sv */
// WAV header parser.
// Slave stream: one header byte per request in s_axis_tdata, s_axis_tuser
// high on byte 0 of a header (restarts the parse). Bytes seen before any
// first byte, or after a header's result, are dropped with no result.
// Master stream: at most one result request per header, on the first error or after
// the last data size byte; status 0 means a valid PCM header.
// cfg_wr_en/cfg_wr_data load the expected total file length; write it only
// while no header is in flight.
// Throughput: one byte per cycle while the master side does not stall. Latency:
// two register stages; a byte taken into the input register is parsed from
// there and its result is registered onto the master side when the core accepts it.
// Reset clears both stream registers, sets the file length to 0 and leaves
// the parser waiting for a first byte.
// When m_axis_tready is low with a result held, the parser stalls: the next
// byte waits in the input register and tready drops once it is full.
`default_nettype none

module wav_header_parser_unit #(
  parameter int LIST_LIMIT = wavhp_pkg::LIST_LIMIT_DEF
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,   // [7:0] header_byte
  input  wire         s_axis_tuser,   // [0] first_byte
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // [3:0] status, [5:4] channel_count, [37:6] sample_rate, [69:38] byte_rate,
  // [85:70] block_align, [101:86] sample_bits, [133:102] data_size,
  // [142:134] header_length, [143] zero
  output logic [wavhp_pkg::TDATA_W-1:0] m_axis_tdata,
  input  wire         cfg_wr_en,
  input  wire  [31:0] cfg_wr_data
);
  import wavhp_pkg::*;

  logic [31:0]   file_length;
  wavhp_item_t   s_item;
  wavhp_item_t   q_item;
  logic          q_valid;
  logic          q_ready;
  wavhp_result_t result;

  always_ff @(posedge clk) begin
    if (rst) begin
      file_length <= '0;
    end else if (cfg_wr_en) begin
      file_length <= cfg_wr_data;
    end
  end

  assign s_item.header_byte = s_axis_tdata;
  assign s_item.first_byte  = s_axis_tuser;

  wavhp_in_stage u_in (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .s_ready (s_axis_tready),
    .s_item  (s_item),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_item  (q_item)
  );

  wavhp_core #(
    .LIST_LIMIT (LIST_LIMIT)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (q_valid),
    .in_ready    (q_ready),
    .in_item     (q_item),
    .file_length (file_length),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_result  (result)
  );

  assign m_axis_tdata = {{(TDATA_W - RESULT_W){1'b0}}, result};

endmodule

`default_nettype wire

/* tb/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wavhp_pkg::*;

  localparam int PIPE_DELAY  = 4;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 2000;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata = '0;
  logic                s_axis_tuser = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [TDATA_W-1:0]  m_axis_tdata;
  logic                cfg_wr_en = 1'b0;
  logic [31:0]         cfg_wr_data = '0;

  wav_header_parser_unit dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  // parser state as the block should hold it
  logic [31:0] file_len_model = '0;
  logic [31:0] pos_m = '0;
  logic [31:0] shift_m = '0;
  bit          list_m = 1'b0;
  logic [32:0] tag_pos_m = 33'd36;
  bit          done_m = 1'b1;
  logic [1:0]  chan_m = '0;
  logic [31:0] rate_m = '0;
  logic [31:0] brate_m = '0;
  logic [15:0] align_m = '0;
  logic [15:0] bits_m = '0;

  wavhp_result_t header_reports[$];
  logic [7:0]    hdr[$];
  int            fail_count = 0;
  int            bytes_parsed = 0;
  int            reports_predicted = 0;
  int            idle_cycles = 0;
  int            sink_left = 0;
  int            hold_count = 0;
  bit            hold_request = 1'b0;
  bit            steady = 1'b0;

  function automatic void clear_capture();
    pos_m = '0;
    shift_m = '0;
    list_m = 1'b0;
    tag_pos_m = 33'd36;
    chan_m = '0;
    rate_m = '0;
    brate_m = '0;
    align_m = '0;
    bits_m = '0;
  endfunction

  function automatic bit parse_byte(input logic [7:0] b, input bit first,
                                    output wavhp_result_t rep);
    logic [31:0] w, wle, pos;
    logic [15:0] h;
    logic [32:0] list_end;
    logic [3:0]  st;
    bit          hit, claimed;
    rep = '0;
    if (first) begin
      clear_capture();
      done_m = 1'b0;
    end
    if (done_m) return 1'b0;
    bytes_parsed++;
    shift_m = {shift_m[23:0], b};
    w = shift_m;
    wle = {w[7:0], w[15:8], w[23:16], w[31:24]};
    h = {w[7:0], w[15:8]};
    pos = pos_m;
    pos_m = pos + 32'd1;
    hit = 1'b0;
    claimed = 1'b0;
    st = ST_OK;
    case (pos)
      32'd3: if (w != TAG_RIFF) begin
        hit = 1'b1; st = ST_RIFF_TAG;
      end
      32'd7: if (wle + 32'd8 != file_len_model) begin
        hit = 1'b1; st = ST_RIFF_SIZE;
      end
      32'd11: if (w != TAG_WAVE) begin
        hit = 1'b1; st = ST_WAVE_TAG;
      end
      32'd15: if (w != TAG_FMT) begin
        hit = 1'b1; st = ST_FMT_TAG;
      end
      32'd19: if (wle != FMT_LEN) begin
        hit = 1'b1; st = ST_FMT_SIZE;
      end
      32'd21: if (h != FMT_PCM) begin
        hit = 1'b1; st = ST_FORMAT;
      end
      32'd23: if (h != 16'd1 && h != 16'd2) begin
        hit = 1'b1; st = ST_CHANNELS;
      end else begin
        chan_m = h[1:0];
      end
      32'd27: rate_m = wle;
      32'd31: brate_m = wle;
      32'd33: align_m = h;
      32'd35: begin
        bits_m = h;
        if (h != 16'd8 && h != 16'd16 && h != 16'd24) begin
          hit = 1'b1; st = ST_BITS;
        end
      end
      32'd39: if (!list_m && w == TAG_LIST) begin
        list_m = 1'b1;
        claimed = 1'b1;
      end
      default: ;
    endcase
    if (!hit && !claimed) begin
      if (list_m && pos == 32'd43) begin
        list_end = 33'd44 + {1'b0, wle};
        if (list_end >= LIST_LIMIT_DEF) begin
          hit = 1'b1; st = ST_LIST_SIZE;
        end else begin
          tag_pos_m = list_end;
        end
      end else if ({1'b0, pos} == tag_pos_m + 33'd3) begin
        if (w != TAG_DATA) begin
          hit = 1'b1; st = ST_DATA_TAG;
        end
      end else if ({1'b0, pos} == tag_pos_m + 33'd7) begin
        hit = 1'b1;
        rep.data_size = wle;
        rep.header_length = tag_pos_m[8:0] + 9'd8;
      end
    end
    if (!hit) return 1'b0;
    done_m = 1'b1;
    rep.status = st;
    rep.channel_count = chan_m;
    rep.sample_rate = rate_m;
    rep.byte_rate = brate_m;
    rep.block_align = align_m;
    rep.sample_bits = bits_m;
    return 1'b1;
  endfunction

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s expected %0h actual %0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : report_sink
    if (hold_request) begin
      m_axis_tready <= 1'b0;
      hold_count++;
      if (hold_count == HOLD_CYCLES) begin
        hold_count = 0;
        hold_request = 1'b0;
      end
    end else if (steady) begin
      m_axis_tready <= 1'b1;
    end else if (sink_left != 0) begin
      sink_left--;
    end else if (m_axis_tready) begin
      sink_left = pick_gap();
      m_axis_tready <= (sink_left == 0);
    end else begin
      sink_left = $urandom_range(1, 12);
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : report_checker
    wavhp_result_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[RESULT_W-1:0];
      if (header_reports.size() == 0) begin
        $display("%0t ns: report expected none actual status %0d", $time, got.status);
        fail_count++;
      end else begin
        want = header_reports.pop_front();
        check_field("status", want.status, got.status);
        check_field("channel_count", want.channel_count, got.channel_count);
        check_field("sample_rate", want.sample_rate, got.sample_rate);
        check_field("byte_rate", want.byte_rate, got.byte_rate);
        check_field("block_align", want.block_align, got.block_align);
        check_field("sample_bits", want.sample_bits, got.sample_bits);
        check_field("data_size", want.data_size, got.data_size);
        check_field("header_length", want.header_length, got.header_length);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles == STALL_LIMIT) begin
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  // one byte request; returns at the edge that accepts it
  task automatic send_byte(input logic [7:0] b, input bit first);
    int gap;
    wavhp_result_t rep;
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tuser <= first;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (parse_byte(b, first, rep)) begin
      header_reports.push_back(rep);
      reports_predicted++;
    end
  endtask

  // stops once the header has raised its report
  task automatic send_header();
    int i, start;
    start = reports_predicted;
    for (i = 0; i < hdr.size() && reports_predicted == start; i++)
      send_byte(hdr[i], i == 0);
  endtask

  task automatic send_junk(input int n, input bit with_first);
    repeat (n) send_byte(8'($urandom), with_first && $urandom_range(7) == 0);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (header_reports.size() != 0) @(posedge clk);
    repeat (PIPE_DELAY) @(posedge clk);
  endtask

  task automatic set_file_length(input logic [31:0] len);
    settle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= len;
    file_len_model = len;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic void put_be32(input logic [31:0] v);
    hdr.push_back(v[31:24]);
    hdr.push_back(v[23:16]);
    hdr.push_back(v[15:8]);
    hdr.push_back(v[7:0]);
  endfunction

  function automatic void put_le16(input logic [15:0] v);
    hdr.push_back(v[7:0]);
    hdr.push_back(v[15:8]);
  endfunction

  function automatic void put_le32(input logic [31:0] v);
    put_le16(v[15:0]);
    put_le16(v[31:16]);
  endfunction

  function automatic void build_header(input logic [31:0] riff_size,
                                       input logic [15:0] chans, input logic [15:0] bits,
                                       input bit with_list, input logic [31:0] list_size,
                                       input logic [31:0] dsize);
    hdr.delete();
    put_be32(TAG_RIFF);
    put_le32(riff_size);
    put_be32(TAG_WAVE);
    put_be32(TAG_FMT);
    put_le32(FMT_LEN);
    put_le16(FMT_PCM);
    put_le16(chans);
    put_le32($urandom);
    put_le32($urandom);
    put_le16(16'($urandom));
    put_le16(bits);
    if (with_list) begin
      put_be32(TAG_LIST);
      put_le32(list_size);
      if (64'd44 + list_size < LIST_LIMIT_DEF) repeat (list_size) hdr.push_back(8'($urandom));
    end
    put_be32(TAG_DATA);
    put_le32(dsize);
  endfunction

  function automatic void random_header();
    logic [31:0] riff, lsize;
    logic [15:0] chans, bits;
    int r, idx;
    riff = ($urandom_range(15) == 0) ? $urandom : file_len_model - 32'd8;
    chans = ($urandom_range(15) == 0) ? 16'($urandom) : 16'($urandom_range(1, 2));
    r = $urandom_range(19);
    bits = (r == 0) ? 16'($urandom) : (r < 7) ? 16'd8 : (r < 13) ? 16'd16 : 16'd24;
    r = $urandom_range(99);
    lsize = (r < 85) ? 32'($urandom_range(0, 12)) :
            (r < 92) ? 32'($urandom_range(440, 470)) : $urandom;
    build_header(riff, chans, bits, $urandom_range(2) == 0, lsize, $urandom);
    if ($urandom_range(2) == 0) begin
      idx = $urandom_range(0, hdr.size() - 1);
      hdr[idx] = hdr[idx] ^ (8'h01 << $urandom_range(0, 7));
    end
  endfunction

  task automatic test_ignored_bytes();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_junk(3, 1'b0);
    settle();
  endtask

  task automatic test_reset_length();
    build_header(32'hFFFF_FFF8, 16'd2, 16'd16, 1'b0, '0, 32'h0000_1000);
    send_header();
    send_junk(4, 1'b0);
    settle();
  endtask

  task automatic test_length_extremes();
    set_file_length(32'h0000_0000);
    build_header(32'hFFFF_FFF8, 16'd1, 16'd8, 1'b1, 32'd0, 32'd0);
    send_header();
    set_file_length(32'hFFFF_FFFF);
    build_header(32'hFFFF_FFF7, 16'd2, 16'd24, 1'b0, '0, 32'hFFFF_FFFF);
    send_header();
    build_header(32'hFFFF_FFF8, 16'd2, 16'd24, 1'b0, '0, 32'h10);
    send_header();
    set_file_length(32'd7);
    build_header(32'hFFFF_FFFF, 16'd1, 16'd16, 1'b0, '0, 32'h20);
    send_header();
    settle();
  endtask

  task automatic test_list_chunk();
    int i;
    set_file_length(32'd1234);
    // last size that still fits under the limit: no report up to the size bytes
    build_header(32'd1226, 16'd1, 16'd8, 1'b1, 32'd455, 32'h66);
    for (i = 0; i < 44; i++) send_byte(hdr[i], i == 0);
    build_header(32'd1226, 16'd1, 16'd8, 1'b1, 32'd456, 32'h66);
    send_header();
    build_header(32'd1226, 16'd2, 16'd24, 1'b1, 32'hFFFF_FFFF, 32'h66);
    send_header();
    settle();
  endtask

  task automatic test_tag_errors();
    build_header(32'd1226, 16'd2, 16'd16, 1'b0, '0, 32'h1);
    hdr[1] = 8'h00;
    send_header();
    build_header(32'd1226, 16'd2, 16'd16, 1'b0, '0, 32'h1);
    hdr[11] = hdr[11] ^ 8'h01;
    send_header();
    build_header(32'd1226, 16'd2, 16'd16, 1'b0, '0, 32'h1);
    hdr[15] = 8'h00;
    send_header();
    build_header(32'd1226, 16'd2, 16'd16, 1'b0, '0, 32'h1);
    hdr[16] = 8'h12;
    send_header();
    build_header(32'd1226, 16'd2, 16'd16, 1'b0, '0, 32'h1);
    hdr[20] = 8'hFE;
    send_header();
    build_header(32'd1226, 16'd2, 16'd16, 1'b0, '0, 32'h1);
    hdr[36] = 8'h44;
    send_header();
    settle();
  endtask

  task automatic test_format_fields();
    build_header(32'd1226, 16'd3, 16'd16, 1'b0, '0, 32'h1);
    send_header();
    build_header(32'd1226, 16'd1, 16'd12, 1'b0, '0, 32'h1);
    send_header();
    build_header(32'd1226, 16'd2, 16'hFFFF, 1'b0, '0, 32'h1);
    send_header();
    settle();
  endtask

  task automatic test_restart();
    int i;
    build_header(32'd1226, 16'd2, 16'd16, 1'b0, '0, 32'h100);
    for (i = 0; i < 21; i++) send_byte(hdr[i], i == 0);
    // cut off again in the middle of the LIST size
    build_header(32'd1226, 16'd1, 16'd8, 1'b1, 32'd4, 32'h40);
    for (i = 0; i < 41; i++) send_byte(hdr[i], i == 0);
    send_header();
    settle();
  endtask

  task automatic test_backpressure();
    int n;
    logic [7:0] lead;
    hold_request = 1'b1;
    for (n = 0; n < 4; n++) begin
      lead = 8'($urandom);
      if (lead == TAG_RIFF[31:24]) lead = ~lead;
      send_byte(lead, 1'b1);
      repeat (3) send_byte(8'($urandom), 1'b0);
    end
    build_header(file_len_model - 32'd8, 16'd2, 16'd24, 1'b0, '0, $urandom);
    send_header();
    settle();
  endtask

  task automatic test_random();
    int parsed_start, reports_start, iter, r, cut;
    parsed_start = bytes_parsed;
    reports_start = reports_predicted;
    iter = 0;
    while (bytes_parsed - parsed_start < 40 || reports_predicted - reports_start < 2) begin
      iter++;
      if (iter % 3 == 0) begin
        r = $urandom_range(3);
        steady = 1'b0;
        set_file_length(r == 0 ? 32'h0 : r == 1 ? 32'hFFFF_FFFF : $urandom);
      end
      steady = ($urandom_range(7) == 0);
      r = $urandom_range(99);
      if (r < 10) begin
        send_junk($urandom_range(1, 8), 1'b1);
      end else begin
        random_header();
        if (r < 18) begin
          cut = $urandom_range(1, hdr.size() - 1);
          while (hdr.size() > cut) void'(hdr.pop_back());
        end
        send_header();
        if ($urandom_range(3) == 0) send_junk($urandom_range(1, 4), 1'b0);
      end
    end
    steady = 1'b0;
    settle();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_ignored_bytes();
    test_reset_length();
    test_length_extremes();
    test_list_chunk();
    test_tag_errors();
    test_format_fields();
    test_restart();
    test_backpressure();
    test_random();
    settle();
    if (fail_count == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end

endmodule
